### hdl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, constants and helpers of the segment admissibility checker.
// ----------------------------------------------------------------------------
package sac_pkg;

  // fixed-point format and widths of the values
  localparam int unsigned FRAC = 24;
  localparam int unsigned VW   = 48;
  localparam int unsigned LW   = 17;
  localparam int unsigned AW   = 25;

  localparam logic [LW-1:0] MAX_SEG_LEN = 17'd65536;
  localparam logic [LW-1:0] MIN_SEG_LEN = 17'd1;

  // configuration register indexes
  localparam logic [1:0] REG_STATS_MIN  = 2'd0;
  localparam logic [1:0] REG_STATS_MAX  = 2'd1;
  localparam logic [1:0] REG_STATS_MEAN = 2'd2;
  localparam logic [1:0] REG_ACCURACY   = 2'd3;

  // segment flag bits
  localparam int unsigned FLAG_START = 0;
  localparam int unsigned FLAG_END   = 1;
  localparam int unsigned FLAG_DEGEN = 2;

  // one classified transaction as held in the queue
  typedef struct packed {
    logic                 setup;
    logic signed [VW-1:0] left;
    logic signed [VW-1:0] middle;
    logic                 last;
    logic signed [VW-1:0] delta;
    logic signed [VW-1:0] mean;
    logic [LW-1:0]        len;
    logic signed [VW-1:0] first;
    logic [2:0]           flags;
  } item_t;

  // magnitude of a 48-bit signed value
  function automatic logic [VW-1:0] mag48(input logic signed [VW-1:0] v);
    mag48 = v[VW-1] ? (~v + 48'd1) : v;
  endfunction

  // magnitude of a 49-bit signed value known to stay below 2^48
  function automatic logic [VW-1:0] mag49(input logic signed [VW:0] v);
    logic [VW:0] m;
    m = v[VW] ? (~v + 49'd1) : v;
    mag49 = m[VW-1:0];
  endfunction

  // saturate a 49-bit signed value to 48 bits
  function automatic logic signed [VW-1:0] sat49(input logic signed [VW:0] v);
    if (v[VW] != v[VW-1]) begin
      sat49 = v[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sat49 = v[VW-1:0];
    end
  endfunction

  // scale an exact magnitude product, saturate and apply the sign
  function automatic logic signed [VW-1:0] prod_fin(input logic [2*VW-1:0] p,
                                                   input logic neg);
    logic [2*VW-FRAC-1:0] sh;
    logic [2*VW-FRAC-1:0] lim;
    logic [VW-1:0]        m;
    sh  = p[2*VW-1:FRAC];
    lim = neg ? {{(VW-FRAC){1'b0}}, 1'b1, {(VW-1){1'b0}}}
              : {{(VW-FRAC+1){1'b0}}, {(VW-1){1'b1}}};
    m   = (sh > lim) ? lim[VW-1:0] : sh[VW-1:0];
    prod_fin = neg ? (~m + 48'd1) : m;
  endfunction

endpackage

### hdl/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front
// Accepts transactions, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sac_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic signed [47:0]          left_coef,
  input  logic signed [47:0]          middle_coef,
  input  logic                        last_element,
  input  logic signed [47:0]          seg_delta,
  input  logic signed [47:0]          seg_mean,
  input  logic [16:0]                 seg_length,
  input  logic signed [47:0]          first_margin,
  input  logic                        starts_at_zero,
  input  logic                        ends_at_one,
  input  logic                        upper_bound_zero,
  output logic                        q_valid,
  output sac_pkg::item_t              q_item,
  input  logic                        q_pop
);
  import sac_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  // classify: clamp the length and pack the flags
  always_comb begin
    cls.setup  = operation;
    cls.left   = left_coef;
    cls.middle = middle_coef;
    cls.last   = last_element;
    cls.delta  = seg_delta;
    cls.mean   = seg_mean;
    cls.first  = first_margin;
    cls.flags  = {upper_bound_zero, ends_at_one, starts_at_zero};
    if (seg_length < MIN_SEG_LEN) begin
      cls.len = MIN_SEG_LEN;
    end else if (seg_length > MAX_SEG_LEN) begin
      cls.len = MAX_SEG_LEN;
    end else begin
      cls.len = seg_length;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### hdl/sac_mul.sv
// ----------------------------------------------------------------------------
// sac_mul
// 48 x 48 unsigned multiplier, one 24 x 24 partial product per cycle.
// ----------------------------------------------------------------------------
module sac_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [47:0] b,
  output logic        done,
  output logic [95:0] p
);
  import sac_pkg::*;

  logic [47:0] ar;
  logic [47:0] br;
  logic [1:0]  cnt;
  logic        busy;
  logic [23:0] ah;
  logic [23:0] bh;
  logic [47:0] part;
  logic [95:0] shifted;

  // select the halves for this step and align the partial product
  always_comb begin
    ah   = cnt[1] ? ar[47:24] : ar[23:0];
    bh   = cnt[0] ? br[47:24] : br[23:0];
    part = ah * bh;
    case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    shifted = {48'd0, part};
      2'd1:    shifted = {24'd0, part, 24'd0};
      default: shifted = {part, 48'd0};
    endcase
  end

  // accumulate the four partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar <= a;
      br <= b;
      p  <= '0;
    end else if (busy) begin
      p <= p + shifted;
    end
  end

endmodule

### hdl/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back
// Sequencer that carries out setup and coefficient transactions.
// ----------------------------------------------------------------------------
module sac_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               q_valid,
  input  sac_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               admissible
);
  import sac_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SDIV = 4'd1;
  localparam logic [3:0] S_MARG = 4'd2;
  localparam logic [3:0] S_QDIV = 4'd3;
  localparam logic [3:0] S_MX   = 4'd4;
  localparam logic [3:0] S_MT   = 4'd5;
  localparam logic [3:0] S_MS   = 4'd6;
  localparam logic [3:0] S_END  = 4'd7;
  localparam logic [3:0] S_CS   = 4'd8;
  localparam logic [3:0] S_CSW  = 4'd9;
  localparam logic [3:0] S_CE   = 4'd10;
  localparam logic [3:0] S_CEW  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [25:0] ONE = 26'd1 << FRAC;

  logic [3:0]           state;
  logic signed [47:0]   st_min;
  logic signed [47:0]   st_max;
  logic signed [47:0]   st_mean;
  logic [24:0]          accuracy;
  logic signed [47:0]   prev_margin;
  logic                 failed;
  logic signed [47:0]   cur_delta;
  logic signed [47:0]   cur_mean;
  logic signed [47:0]   step_scale;
  logic [2:0]           segment_flags;
  item_t                it;
  logic signed [47:0]   marg;
  logic signed [48:0]   diff;
  logic [25:0]          xr;
  logic signed [47:0]   px;
  logic [48:0]          rem;
  logic [47:0]          quo;
  logic [5:0]           cnt;
  logic                 dneg;
  logic                 ok;
  logic                 mul_neg;

  logic                 mul_start;
  logic [47:0]          mul_a;
  logic [47:0]          mul_b;
  logic                 mul_done;
  logic [95:0]          mul_p;
  logic                 mul_neg_next;

  logic signed [47:0]   prod_res;
  logic signed [48:0]   mt;
  logic signed [47:0]   margin_c;
  logic signed [48:0]   diff_c;
  logic signed [47:0]   lo_c;
  logic [47:0]          magd;
  logic                 cond;
  logic [17:0]          srem;
  logic                 sge;
  logic [48:0]          r2;
  logic                 qge;
  logic [23:0]          q_c;
  logic [25:0]          x_c;
  logic signed [26:0]   xm1;
  logic signed [49:0]   minv;
  logic signed [47:0]   sx;
  logic signed [47:0]   ex;
  logic signed [48:0]   num_s;
  logic signed [48:0]   den_s;
  logic signed [48:0]   num_e;
  logic signed [48:0]   den_e;
  logic [95:0]          lhs_s;
  logic [95:0]          lhs_e;
  logic                 bad_s;
  logic                 bad_e;
  logic [47:0]          q_fin;

  sac_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // datapath terms
  always_comb begin
    prod_res = prod_fin(mul_p, mul_neg);
    mt       = {prod_res[47], prod_res} - {it.left[47], it.left};
    margin_c = sat49(mt);
    diff_c   = {margin_c[47], margin_c} - {prev_margin[47], prev_margin};
    lo_c     = (margin_c < prev_margin) ? margin_c : prev_margin;
    magd     = mag49(diff_c);
    cond     = ($signed({2'b00, magd}) < $signed({{2{step_scale[47]}}, step_scale})) &&
               ($signed({lo_c, 2'b00}) < $signed({{2{step_scale[47]}}, step_scale}));
    // setup division step
    srem     = {rem[16:0], quo[47]};
    sge      = (srem >= {1'b0, it.len});
    q_fin    = {quo[46:0], sge};
    // subsegment quotient step
    r2       = {rem[47:0], 1'b0};
    qge      = (r2 >= {1'b0, step_scale});
    q_c      = {quo[22:0], qge};
    x_c      = diff[48] ? ((ONE + {2'b00, q_c}) >> 1) : ((ONE - {2'b00, q_c}) >> 1);
    xm1      = $signed({1'b0, xr}) - $signed({1'b0, ONE});
    minv     = {{2{prev_margin[47]}}, prev_margin} + {{2{px[47]}}, px} +
               {{2{prod_res[47]}}, prod_res};
    // end checks
    sx       = sat49({cur_mean[47], cur_mean} - {cur_delta[47], cur_delta});
    ex       = sat49({cur_mean[47], cur_mean} + {cur_delta[47], cur_delta});
    num_s    = {sx[47], sx} - {st_min[47], st_min};
    den_s    = {st_mean[47], st_mean} - {st_min[47], st_min};
    num_e    = {ex[47], ex} - {st_max[47], st_max};
    den_e    = {st_max[47], st_max} - {st_mean[47], st_mean};
    lhs_s    = {24'd0, mag49(num_s), 24'd0};
    lhs_e    = {24'd0, mag49(num_e), 24'd0};
    bad_s    = (den_s == 49'sd0) ? (num_s != 49'sd0) : (lhs_s >= mul_p);
    bad_e    = (den_e == 49'sd0) ? (num_e != 49'sd0) : (lhs_e >= mul_p);
  end

  // multiplier requests
  always_comb begin
    q_pop        = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    mul_neg_next = mul_neg;
    unique case (state)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid && !q_item.setup) begin
          mul_start    = 1'b1;
          mul_a        = mag48(q_item.middle);
          mul_b        = mag48(cur_delta);
          mul_neg_next = q_item.middle[47] ^ cur_delta[47];
        end
      end
      S_QDIV: begin
        if (cnt == 6'd23) begin
          mul_start    = 1'b1;
          mul_a        = {22'd0, x_c};
          mul_b        = mag49(diff);
          mul_neg_next = diff[48];
        end
      end
      S_MX: begin
        if (mul_done) begin
          mul_start    = 1'b1;
          mul_a        = {22'd0, xr};
          mul_b        = {21'd0, xm1[26] ? (~xm1 + 27'd1) : xm1};
          mul_neg_next = xm1[26];
        end
      end
      S_MT: begin
        if (mul_done) begin
          mul_start    = 1'b1;
          mul_a        = mag48(step_scale);
          mul_b        = mag48(prod_res);
          mul_neg_next = step_scale[47] ^ prod_res[47];
        end
      end
      S_CS: begin
        if (ok && segment_flags[FLAG_START]) begin
          mul_start = 1'b1;
          mul_a     = {23'd0, accuracy};
          mul_b     = mag49(den_s);
        end
      end
      S_CE: begin
        if (ok && segment_flags[FLAG_END]) begin
          mul_start = 1'b1;
          mul_a     = {23'd0, accuracy};
          mul_b     = mag49(den_e);
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st_min   <= '0;
      st_max   <= '0;
      st_mean  <= '0;
      accuracy <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATS_MIN:  st_min   <= cfg_data;
        REG_STATS_MAX:  st_max   <= cfg_data;
        REG_STATS_MEAN: st_mean  <= cfg_data;
        REG_ACCURACY:   accuracy <= cfg_data[AW-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_margin   <= '0;
      failed        <= 1'b0;
      cur_delta     <= '0;
      cur_mean      <= '0;
      step_scale    <= '0;
      segment_flags <= '0;
      out_valid     <= 1'b0;
      mul_neg       <= 1'b0;
      cnt           <= '0;
      ok            <= 1'b0;
    end else begin
      mul_neg <= mul_neg_next;
      // the output is cleared once the result is taken, unless a new one is loaded
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            if (q_item.setup) begin
              cur_delta     <= q_item.delta;
              cur_mean      <= q_item.mean;
              prev_margin   <= q_item.first;
              failed        <= 1'b0;
              segment_flags <= q_item.flags;
              rem           <= '0;
              quo           <= mag48(q_item.delta);
              dneg          <= q_item.delta[47];
              cnt           <= '0;
              state         <= S_SDIV;
            end else begin
              state <= S_MARG;
            end
          end
        end
        S_SDIV: begin
          rem <= {31'd0, sge ? (srem - {1'b0, it.len}) : srem};
          quo <= q_fin;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) begin
            step_scale <= dneg ? (~q_fin + 48'd1) : q_fin;
            state      <= S_IDLE;
          end
        end
        S_MARG: begin
          if (mul_done) begin
            marg <= margin_c;
            diff <= diff_c;
            rem  <= {1'b0, magd};
            quo  <= '0;
            cnt  <= '0;
            state <= cond ? S_QDIV : S_END;
          end
        end
        S_QDIV: begin
          rem <= qge ? (r2 - {1'b0, step_scale}) : r2;
          quo <= {quo[46:0], qge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd23) begin
            xr    <= x_c;
            state <= S_MX;
          end
        end
        S_MX: begin
          if (mul_done) begin
            px    <= prod_res;
            state <= S_MT;
          end
        end
        S_MT: begin
          if (mul_done) begin
            state <= S_MS;
          end
        end
        S_MS: begin
          if (mul_done) begin
            if (minv < 50'sd0) begin
              failed <= 1'b1;
            end
            state <= S_END;
          end
        end
        S_END: begin
          prev_margin <= marg;
          ok          <= !failed;
          state       <= it.last ? S_CS : S_IDLE;
        end
        S_CS: begin
          state <= (ok && segment_flags[FLAG_START]) ? S_CSW : S_CE;
        end
        S_CSW: begin
          if (mul_done) begin
            if (bad_s) begin
              ok <= 1'b0;
            end
            state <= S_CE;
          end
        end
        S_CE: begin
          state <= (ok && segment_flags[FLAG_END]) ? S_CEW : S_OUT;
        end
        S_CEW: begin
          if (mul_done) begin
            if (bad_e) begin
              ok <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            admissible <= segment_flags[FLAG_DEGEN] | ok;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/segment_admissibility_check_unit.sv
// ----------------------------------------------------------------------------
// segment_admissibility_check_unit
// Strict admissibility check of one piecewise-linear segment, Q24.24.
// ----------------------------------------------------------------------------
// A setup transaction carries out the bit-serial division of delta by the
// segment length. A coefficient transaction runs its margin product; when the
// subsegment test runs it adds the quotient iteration and three more products.
// The last element adds up to two end checks, each a product on the shared
// multiplier, and a step to load the result. A two-entry queue in front lets
// new transactions arrive while one is at work.
module segment_admissibility_check_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [47:0] left_coef,
  input  logic signed [47:0] middle_coef,
  input  logic               last_element,
  input  logic signed [47:0] seg_delta,
  input  logic signed [47:0] seg_mean,
  input  logic [16:0]        seg_length,
  input  logic signed [47:0] first_margin,
  input  logic               starts_at_zero,
  input  logic               ends_at_one,
  input  logic               upper_bound_zero,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               admissible
);
  import sac_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  sac_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .left_coef        (left_coef),
    .middle_coef      (middle_coef),
    .last_element     (last_element),
    .seg_delta        (seg_delta),
    .seg_mean         (seg_mean),
    .seg_length       (seg_length),
    .first_margin     (first_margin),
    .starts_at_zero   (starts_at_zero),
    .ends_at_one      (ends_at_one),
    .upper_bound_zero (upper_bound_zero),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  sac_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .admissible (admissible)
  );

endmodule

### hdl/sac_checker.sv
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks of the segment admissibility checker.
// ----------------------------------------------------------------------------
module sac_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic admissible
);

  // queue and output are empty out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // a held result keeps its verdict
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(admissible))
    else $error("stalled result changed");

  // the queue does not fill without a transaction being accepted
  a_fill: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !(in_valid && !in_stall) |=> !in_stall)
    else $error("queue full without a transaction");

  // no result straight out of reset
  a_first: assert property (@(posedge clk) $rose(out_valid) |-> !$past(rst))
    else $error("result during reset");

endmodule

bind segment_admissibility_check_unit sac_checker u_chk (.*);
